/* rtl/core/seven_segment_scan_display_unit_defines.svh */
// Assertion macros for the seven-segment scan display unit.
// Each check runs on clk_i and is held off while rst_ni is low.
`ifndef SEVEN_SEGMENT_SCAN_DISPLAY_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DISPLAY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSD_ASSERT(lbl, prop, msg)
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/ssd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // command codes
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_TIME  = 3'd1;
  localparam logic [2:0] FUNC_TEMP  = 3'd2;
  localparam logic [2:0] FUNC_DEC   = 3'd3;
  localparam logic [2:0] FUNC_RAW   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DIGITS = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;

  localparam logic [2:0]  DIGITS_RST      = 3'd4;
  localparam logic [15:0] SCAN_PERIOD_RST = 16'd2;

  localparam logic [7:0] GLYPH_POINT   = 8'h80;
  localparam logic [7:0] GLYPH_MINUS   = 8'h01;
  localparam logic [7:0] GLYPH_CELSIUS = 8'h4E;
  localparam logic [7:0] GLYPH_BLANK   = 8'h00;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        hours_bcd;
    logic [7:0]        minutes_bcd;
    logic signed [7:0] temperature;
    logic [7:0]        digit_index;
    logic [7:0]        digit_value;
    logic              with_point;
  } ssd_item_t;

  // pattern writes requested by one command
  typedef struct packed {
    logic            quad_we;   // digits 0..3 all at once
    logic [3:0][7:0] quad_pat;
    logic            one_we;    // single digit
    logic [7:0]      one_idx;
    logic [7:0]      one_pat;
  } ssd_wr_t;

  typedef struct packed {
    logic       strobe;
    logic [1:0] sel;
    logic [7:0] pattern;
  } ssd_scan_t;

  typedef struct packed {
    logic [1:0] status;
    logic       strobe_res;
    logic [1:0] digit_select;
    logic [7:0] segment_pattern;
  } ssd_result_t;

  function automatic logic [7:0] glyph_of(input logic [3:0] v);
    logic [7:0] g;
    unique case (v)
      4'd0:    g = 8'h7E;
      4'd1:    g = 8'h30;
      4'd2:    g = 8'h6D;
      4'd3:    g = 8'h79;
      4'd4:    g = 8'h33;
      4'd5:    g = 8'h5B;
      4'd6:    g = 8'h5F;
      4'd7:    g = 8'h70;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h7B;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ssd_cmd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssd_cmd_decode import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  ssd_item_t                          item_i,
  input  logic [$clog2(DIGIT_COUNT+1)-1:0]   active_n_i,
  output ssd_wr_t                            wr_o,
  output logic [1:0]                         status_o
);

  logic        neg;
  logic [7:0]  mag;
  logic [6:0]  sat;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones;
  logic        idx_bad;

  // magnitude; -128 comes out as 128 and saturates below
  assign neg  = item_i.temperature[7];
  assign mag  = neg ? (~item_i.temperature + 8'd1) : item_i.temperature;
  assign sat  = (mag > 8'd99) ? 7'd99 : mag[6:0];
  // tens = sat / 10 by reciprocal, exact for sat <= 99
  assign prod = 15'(sat) * 15'd205;
  assign tens = prod[14:11];
  assign ones = sat - 7'(tens) * 7'd10;

  assign idx_bad = item_i.digit_index >= 8'(active_n_i);

  always_comb begin
    wr_o          = '0;
    wr_o.one_idx  = item_i.digit_index;
    status_o      = ST_OK;
    case (item_i.func)
      FUNC_TIME: begin
        wr_o.quad_we     = 1'b1;
        wr_o.quad_pat[0] = glyph_of(item_i.hours_bcd[7:4]);
        wr_o.quad_pat[1] = glyph_of(item_i.hours_bcd[3:0]) | GLYPH_POINT;
        wr_o.quad_pat[2] = glyph_of(item_i.minutes_bcd[7:4]);
        wr_o.quad_pat[3] = glyph_of(item_i.minutes_bcd[3:0]);
      end
      FUNC_TEMP: begin
        wr_o.quad_we     = 1'b1;
        wr_o.quad_pat[0] = neg ? GLYPH_MINUS : GLYPH_BLANK;
        wr_o.quad_pat[1] = (sat < 7'd10) ? GLYPH_BLANK : glyph_of(tens);
        wr_o.quad_pat[2] = glyph_of(ones[3:0]);
        wr_o.quad_pat[3] = GLYPH_CELSIUS | GLYPH_POINT;
      end
      FUNC_DEC: begin
        if (idx_bad) begin
          status_o = ST_INDEX;
        end else if (item_i.digit_value > 8'd9) begin
          status_o = ST_RANGE;
        end else begin
          wr_o.one_we  = 1'b1;
          wr_o.one_pat = glyph_of(item_i.digit_value[3:0])
                       | (item_i.with_point ? GLYPH_POINT : GLYPH_BLANK);
        end
      end
      FUNC_RAW: begin
        if (idx_bad) begin
          status_o = ST_INDEX;
        end else begin
          wr_o.one_we  = 1'b1;
          wr_o.one_pat = item_i.digit_value;
        end
      end
      default: ;  // tick and unused codes write nothing
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ssd_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssd_scan import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  logic [15:0]                         scan_period_i,
  input  logic [$clog2(DIGIT_COUNT+1)-1:0]    active_n_i,
  input  logic [DIGIT_COUNT-1:0][7:0]         patterns_i,
  output ssd_scan_t                           scan_o
);

  localparam int IdxW = $clog2(DIGIT_COUNT);
  localparam int CntW = $clog2(DIGIT_COUNT + 1);

  logic [15:0]     cd_q, cd_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] pos_eff;
  logic [CntW-1:0] pos_inc;
  logic            expire;

  assign expire  = cd_q <= 16'd1;
  // count may have shrunk since the last strobe
  assign pos_eff = (CntW'(pos_q) >= active_n_i) ? '0 : pos_q;
  assign pos_inc = CntW'(pos_eff) + CntW'(1);

  always_comb begin
    cd_d   = cd_q;
    pos_d  = pos_q;
    scan_o = '0;
    if (tick_i) begin
      if (expire) begin
        scan_o.strobe  = 1'b1;
        scan_o.sel     = pos_eff[1:0];
        scan_o.pattern = patterns_i[pos_eff];
        pos_d          = (pos_inc >= active_n_i) ? '0 : pos_inc[IdxW-1:0];
        cd_d           = scan_period_i;
      end else begin
        cd_d = cd_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q  <= SCAN_PERIOD_RST;
      pos_q <= '0;
    end else begin
      cd_q  <= cd_d;
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/seven_segment_scan_display_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Multiplexed seven-segment display driver, up to DIGIT_COUNT digits. Each
// item (func in s_axis_tuser_i) is either a tick or a command that loads the
// digit patterns (BCD time, signed temperature, one decimal digit, raw
// pattern). Every item returns exactly one result; a tick that ends the scan
// period strobes out the next digit's index and pattern. Throughput is one
// item per clock while the output is not held: an item is captured in the
// input register, then decoded and applied to the state as it moves into the
// result register; while the output is held, the item waits in the input
// register and no new item is accepted until it moves on to the result register.
// Segment bits: bit7 point, bits 6..0 segments a..g. Configuration is a plain
// write port: index 0 digits in use (3 bits), index 1 scan period (16 bits);
// write only while the block is idle. No clearing pass after reset.

`include "seven_segment_scan_display_unit_defines.svh"

module seven_segment_scan_display_unit import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // in tdata, LSB up: hours_bcd[7:0], minutes_bcd[15:8], temperature[23:16],
  // digit_index[31:24], digit_value[39:32], with_point[40], zero pad
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,
  // in tuser: func[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  // out tdata, LSB up: status[1:0], strobe_res[2], digit_select[4:3],
  // segment_pattern[12:5], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IdxW = $clog2(DIGIT_COUNT);
  localparam int CntW = $clog2(DIGIT_COUNT + 1);
  localparam logic [3:0] MaxN = 4'(DIGIT_COUNT);

  // config registers
  logic [2:0]  digits_q;
  logic [15:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= DIGITS_RST;
      period_q <= SCAN_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIGITS: digits_q <= cfg_data_i[2:0];
        CFG_PERIOD: period_q <= cfg_data_i;
        default: ;  // no register there
      endcase
    end
  end

  // effective digit count: 0 acts as 1, clamp at DIGIT_COUNT
  logic [3:0]      n_raw;
  logic [CntW-1:0] active_n;

  always_comb begin
    n_raw = {1'b0, digits_q};
    if (n_raw == 4'd0) n_raw = 4'd1;
    if (n_raw > MaxN)  n_raw = MaxN;
    active_n = n_raw[CntW-1:0];
  end

  // input register
  logic      in_valid_q;
  ssd_item_t item_q;
  logic      out_valid_q;
  logic      advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.func        <= s_axis_tuser_i;
      item_q.hours_bcd   <= s_axis_tdata_i[7:0];
      item_q.minutes_bcd <= s_axis_tdata_i[15:8];
      item_q.temperature <= s_axis_tdata_i[23:16];
      item_q.digit_index <= s_axis_tdata_i[31:24];
      item_q.digit_value <= s_axis_tdata_i[39:32];
      item_q.with_point  <= s_axis_tdata_i[40];
    end
  end

  // command decode
  ssd_wr_t    wr;
  logic [1:0] cmd_status;

  ssd_cmd_decode #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_decode (
    .item_i     (item_q),
    .active_n_i (active_n),
    .wr_o       (wr),
    .status_o   (cmd_status)
  );

  // digit pattern store
  logic [DIGIT_COUNT-1:0][7:0] pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
    end else if (advance) begin
      if (wr.quad_we) begin
        for (int i = 0; i < 4; i++) pat_q[i] <= wr.quad_pat[i];
      end
      if (wr.one_we) pat_q[wr.one_idx[IdxW-1:0]] <= wr.one_pat;
    end
  end

  // scan timing: countdown and digit position
  ssd_scan_t scan;

  ssd_scan #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (advance && (item_q.func == FUNC_TICK)),
    .scan_period_i (period_q),
    .active_n_i    (active_n),
    .patterns_i    (pat_q),
    .scan_o        (scan)
  );

  // result register
  ssd_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.status          <= cmd_status;
      res_q.strobe_res      <= scan.strobe;
      res_q.digit_select    <= scan.sel;
      res_q.segment_pattern <= scan.pattern;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q.segment_pattern, res_q.digit_select,
                            res_q.strobe_res, res_q.status};

  // checks
  logic res_strobe;
  logic res_quiet;
  logic res_blank;
  logic in_stall;

  assign res_strobe = out_valid_q && res_q.strobe_res;
  assign res_quiet  = out_valid_q && !res_q.strobe_res;
  assign res_blank  = (res_q.digit_select == 2'd0) && (res_q.segment_pattern == 8'd0);
  assign in_stall   = in_valid_q && !advance;

  `SSD_ASSERT(a_strobe_ok, !res_strobe || (res_q.status == ST_OK), "strobe with error")
  `SSD_ASSERT(a_quiet_zero, !res_quiet || res_blank, "non-strobe result has digit data")
  `SSD_ASSERT_NEXT(a_in_hold, in_stall, in_valid_q && $stable(item_q), "stalled item lost")
  `SSD_ASSERT_NEXT(a_adv_out, advance, out_valid_q, "advanced item produced no result")

endmodule

`default_nettype wire

/* tb/seven_segment_scan_display_unit_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the multiplexed seven-segment driver.
// Items go in on the slave stream, results come back one per item on the
// master stream. A shadow copy of the display state (digit patterns, scan
// position, tick countdown, digits in use, scan period) is advanced at every
// accepted item and the result it gives is queued; each result the block
// hands over is checked against the oldest queued one.
module seven_segment_scan_display_unit_test;
  import ssd_pkg::*;

  localparam int DIGIT_SLOTS = 4;

  // segments a..g for 0..9, no point
  localparam logic [7:0] DECIMAL_SEGMENTS [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  // digit count / scan period pairs for the settings sweep, odd ones included
  localparam logic [2:0]  SWEEP_DIGITS [7] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd4};
  localparam logic [15:0] SWEEP_PERIOD [7] = '{16'd1, 16'd0, 16'd3, 16'd1, 16'd2, 16'd1, 16'd1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // LSB up: hours_bcd, minutes_bcd, temperature, digit_index, digit_value,
  // with_point, zero pad
  logic [47:0] s_axis_tdata_i = '0;
  // func
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // LSB up: status, strobe_res, digit_select, segment_pattern, zero pad
  logic [15:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // shadow of the display state, reset values
  logic [7:0]  shadow_pattern [DIGIT_SLOTS] = '{default: GLYPH_BLANK};
  logic [2:0]  shadow_scan_pos = 3'd0;
  logic [15:0] shadow_countdown = SCAN_PERIOD_RST;
  logic [2:0]  shadow_digits = DIGITS_RST;
  logic [15:0] shadow_period = SCAN_PERIOD_RST;

  ssd_result_t display_result_q [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          take_stall_pct = 0;

  seven_segment_scan_display_unit #(
    .DIGIT_COUNT(DIGIT_SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] decimal_segments(input int unsigned d);
    return (d <= 9) ? DECIMAL_SEGMENTS[d] : GLYPH_BLANK;
  endfunction

  // Advance the shadow state by one item and return the result it yields.
  function automatic ssd_result_t display_step(input ssd_item_t it);
    ssd_result_t r;
    int unsigned n;
    int unsigned mag;
    logic [7:0]  traw;
    r = '0;
    // digits in use: 0 acts as 1, anything above the slot count is clamped
    n = (shadow_digits == 3'd0) ? 1 :
        ((shadow_digits > DIGIT_SLOTS) ? DIGIT_SLOTS : int'(shadow_digits));
    traw = it.temperature;
    case (it.func)
      FUNC_TICK: begin
        if (shadow_countdown <= 16'd1) begin
          // count may have shrunk since the last strobe: restart at digit 0
          if (shadow_scan_pos >= n) shadow_scan_pos = 3'd0;
          r.strobe_res      = 1'b1;
          r.digit_select    = shadow_scan_pos[1:0];
          r.segment_pattern = shadow_pattern[shadow_scan_pos[1:0]];
          shadow_scan_pos   = (shadow_scan_pos + 1 >= n) ? 3'd0 : shadow_scan_pos + 3'd1;
          // a period of zero reloads zero, so every tick strobes
          shadow_countdown  = shadow_period;
        end else begin
          shadow_countdown = shadow_countdown - 16'd1;
        end
      end
      FUNC_TIME: begin
        shadow_pattern[0] = decimal_segments(it.hours_bcd[7:4]);
        shadow_pattern[1] = decimal_segments(it.hours_bcd[3:0]) | GLYPH_POINT;
        shadow_pattern[2] = decimal_segments(it.minutes_bcd[7:4]);
        shadow_pattern[3] = decimal_segments(it.minutes_bcd[3:0]);
      end
      FUNC_TEMP: begin
        shadow_pattern[0] = traw[7] ? GLYPH_MINUS : GLYPH_BLANK;
        mag = traw[7] ? 256 - int'(traw) : int'(traw);
        if (mag > 99) mag = 99;
        shadow_pattern[1] = (mag < 10) ? GLYPH_BLANK : decimal_segments(mag / 10);
        shadow_pattern[2] = decimal_segments(mag % 10);
        shadow_pattern[3] = GLYPH_CELSIUS | GLYPH_POINT;
      end
      FUNC_DEC: begin
        // index is checked before the value
        if (it.digit_index >= n) r.status = ST_INDEX;
        else if (it.digit_value > 8'd9) r.status = ST_RANGE;
        else shadow_pattern[it.digit_index[1:0]] = decimal_segments(it.digit_value) |
                                                   (it.with_point ? GLYPH_POINT : GLYPH_BLANK);
      end
      FUNC_RAW: begin
        if (it.digit_index >= n) r.status = ST_INDEX;
        else shadow_pattern[it.digit_index[1:0]] = it.digit_value;
      end
      default: ;  // unused codes leave everything alone
    endcase
    return r;
  endfunction

  function automatic ssd_item_t command_item(input logic [2:0] func,
                                             input logic [7:0] hours, minutes, temp,
                                             input logic [7:0] idx, val,
                                             input logic point);
    ssd_item_t it;
    it.func        = func;
    it.hours_bcd   = hours;
    it.minutes_bcd = minutes;
    it.temperature = temp;
    it.digit_index = idx;
    it.digit_value = val;
    it.with_point  = point;
    return it;
  endfunction

  // Mostly ticks and well-formed commands, with full-range noise mixed in.
  function automatic ssd_item_t random_display_item();
    ssd_item_t   it;
    int unsigned pick;
    it.func        = FUNC_TICK;
    it.hours_bcd   = 8'($urandom);
    it.minutes_bcd = 8'($urandom);
    it.temperature = 8'($urandom);
    it.digit_index = 8'($urandom);
    it.digit_value = 8'($urandom);
    it.with_point  = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.func = FUNC_TICK;
    end else if (pick < 58) begin
      it.func = FUNC_TIME;
      if ($urandom_range(3) != 0) begin
        it.hours_bcd   = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 9))};
        it.minutes_bcd = {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
      end
    end else if (pick < 66) begin
      it.func = FUNC_TEMP;
    end else if (pick < 94) begin
      it.func = (pick < 82) ? FUNC_DEC : FUNC_RAW;
      if ($urandom_range(4) != 0) it.digit_index = 8'($urandom_range(0, 4));
      if (it.func == FUNC_DEC && $urandom_range(4) != 0) it.digit_value = 8'($urandom_range(0, 10));
    end else begin
      it.func = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  function automatic ssd_item_t tick_item();
    ssd_item_t it;
    it = random_display_item();
    it.func = FUNC_TICK;
    return it;
  endfunction

  // One item onto the input stream; valid stays up for a back-to-back item.
  task automatic send_display_item(input ssd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, it.with_point, it.digit_value, it.digit_index,
                        it.temperature, it.minutes_bcd, it.hours_bcd};
    s_axis_tuser_i  <= it.func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    display_result_q.push_back(display_step(it));
  endtask

  // Drop valid and let every owed result come back, plus the pipeline depth.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (display_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DIGITS) shadow_digits = value[2:0];
    else shadow_period = value;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] digits, input logic [15:0] period);
    wait_idle();
    write_config(CFG_DIGITS, {13'd0, digits});
    write_config(CFG_PERIOD, period);
  endtask

  task automatic check_display_result(input logic [15:0] data);
    ssd_result_t want;
    if (display_result_q.size() == 0) begin
      $error("result %h with nothing pending", data);
      fail_count++;
    end else begin
      want = display_result_q.pop_front();
      if (data[1:0] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, data[1:0]);
        fail_count++;
      end
      if (data[2] !== want.strobe_res) begin
        $error("strobe_res: expected %0d, got %0d", want.strobe_res, data[2]);
        fail_count++;
      end
      if (data[4:3] !== want.digit_select) begin
        $error("digit_select: expected %0d, got %0d", want.digit_select, data[4:3]);
        fail_count++;
      end
      if (data[12:5] !== want.segment_pattern) begin
        $error("segment_pattern: expected %h, got %h", want.segment_pattern, data[12:5]);
        fail_count++;
      end
    end
  endtask

  // Output side: check what moves at this edge, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_display_result(m_axis_tdata_o);
    m_axis_tready_i <= ($urandom_range(99) >= take_stall_pct);
  end

  // Reset settings (4 digits, period 2): blank scan, every command kind,
  // field extremes, temperature saturation, error precedence, unused codes.
  task automatic test_reset_and_commands();
    send_display_item(tick_item());
    send_display_item(tick_item());  // first strobe, digit 0 still blank
    send_display_item(command_item(FUNC_TIME, 8'h23, 8'h59, 8'h00, 8'h00, 8'h00, 1'b0));
    send_display_item(tick_item());
    send_display_item(tick_item());  // hours units with point
    // nibbles above 9 go blank
    send_display_item(command_item(FUNC_TIME, 8'hFA, 8'h9F, 8'h00, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'd0, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'd9, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'd10, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'd99, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'd100, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_TEMP, 8'h00, 8'h00, 8'd127, 8'h00, 8'h00, 1'b0));
    send_display_item(command_item(FUNC_DEC, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b1));
    send_display_item(command_item(FUNC_DEC, 8'h00, 8'h00, 8'h00, 8'd3, 8'd9, 1'b0));
    send_display_item(command_item(FUNC_DEC, 8'h00, 8'h00, 8'h00, 8'd3, 8'd10, 1'b1));
    send_display_item(command_item(FUNC_DEC, 8'h00, 8'h00, 8'h00, 8'd4, 8'd5, 1'b0));
    // both wrong: index error wins
    send_display_item(command_item(FUNC_DEC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_display_item(command_item(FUNC_RAW, 8'h00, 8'h00, 8'h00, 8'd1, 8'hFF, 1'b0));
    send_display_item(command_item(FUNC_RAW, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
    send_display_item(command_item(3'd5, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'hFF, 1'b1));
    send_display_item(command_item(3'd6, 8'hFF, 8'hFF, 8'hFF, 8'd1, 8'hFF, 1'b1));
    send_display_item(command_item(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'd2, 8'hFF, 1'b1));
    send_display_item(tick_item());
    send_display_item(tick_item());
  endtask

  // Park the scan on the last digit, then shrink the count under it.
  task automatic test_scan_wrap_on_shrink();
    set_config(3'd4, 16'd1);
    while (shadow_scan_pos != 3'd3) send_display_item(tick_item());
    set_config(3'd2, 16'd1);
    repeat (4) send_display_item(tick_item());
  endtask

  task automatic test_digit_count_settings();
    for (int i = 0; i < 7; i++) begin
      set_config(SWEEP_DIGITS[i], SWEEP_PERIOD[i]);
      repeat (20) send_display_item(random_display_item());
    end
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int unsigned items);
    logic [2:0]  digits;
    logic [15:0] period;
    send_idle_pct  = sender_pct;
    take_stall_pct = receiver_pct;
    repeat (4) begin
      digits = ($urandom_range(9) < 2) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      case ($urandom_range(9))
        0:       period = 16'd0;
        1:       period = 16'($urandom_range(5, 40));
        default: period = 16'($urandom_range(1, 4));
      endcase
      set_config(digits, period);
      repeat (items / 4) send_display_item(random_display_item());
    end
  endtask

  // Longest period: run the old count out so the reload takes 65535, then
  // switch to zero; the long count keeps running and no tick strobes, since
  // zero only applies at the next reload.
  task automatic test_long_scan_period();
    int unsigned lead;
    send_idle_pct  = 0;
    take_stall_pct = 0;
    set_config(3'd4, 16'hFFFF);
    lead = (shadow_countdown <= 16'd1) ? 1 : int'(shadow_countdown);
    repeat (lead) send_display_item(tick_item());
    set_config(3'd4, 16'd0);
    repeat (40) send_display_item(tick_item());
    repeat (20) send_display_item(tick_item());
  endtask

  initial begin
    send_idle_pct  = 9;
    take_stall_pct = 87;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_commands();
    test_scan_wrap_on_shrink();
    test_digit_count_settings();
    test_random_traffic(9, 87, 480);
    test_random_traffic(87, 9, 480);
    test_random_traffic(0, 0, 480);
    test_long_scan_period();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
